// ----- src/sha256_stream_hasher_macros.svh -----
// Assertion macros shared by the SHA-256 stream hasher.
// Depends on nothing; included by the top level.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH
// Clocked implication check with asynchronous reset disable.
`define SHA_ASSERT_IMP(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication check.
`define SHA_ASSERT_NXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);
`endif

// ----- src/sha_pkg.sv -----
// Package for the SHA-256 stream hasher: round constants, initial hash,
// helper functions and the state encoding. No dependencies.
package sha_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned WinDepth = 16;
  localparam int unsigned WinAw = 4;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PAD   = 7'b0000010,
    ST_LEN   = 7'b0000100,
    ST_INIT  = 7'b0001000,
    ST_ROUND = 7'b0010000,
    ST_ADD   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction
endpackage

// ----- src/sha_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module sha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- src/sha_round.sv -----
// One SHA-256 compression round on the eight working variables.
// Depends on sha_pkg.
module sha_round import sha_pkg::*; (
  input  logic [31:0] v_i [8],
  input  logic [31:0] k_i,
  input  logic [31:0] w_i,
  output logic [31:0] v_o [8]
);
  logic [31:0] t1, t2;

  always_comb begin
    t1 = v_i[7] + bsig1(v_i[4]) + ((v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6])) + k_i + w_i;
    t2 = bsig0(v_i[0]) + ((v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]));
    v_o[7] = v_i[6];
    v_o[6] = v_i[5];
    v_o[5] = v_i[4];
    v_o[4] = v_i[3] + t1;
    v_o[3] = v_i[2];
    v_o[2] = v_i[1];
    v_o[1] = v_i[0];
    v_o[0] = t1 + t2;
  end
endmodule

// ----- src/sha256_stream_hasher.sv -----
// SHA-256 stream hasher, top level. Takes one byte per request and returns an
// eight-word digest per message. Depends on sha_pkg, sha_ram, sha_round, macros.
//
// A user feeds the message one byte per request; a request with message_end_i
// high closes the message (with or without a byte) and the block answers with
// eight digest requests, H0 first, word_last_o high on H7. A data byte is
// written in the cycle that accepts it, as a byte lane into the schedule
// memory, a 16-entry synchronous RAM that holds the current 64-byte block.
// Every 64th byte starts a compression: ST_INIT loads the working variables,
// then 64 rounds follow in ST_ROUND at one round per cycle, and ST_ADD adds
// them into the chaining value. Each round reads the schedule RAM one round
// ahead; the rolling schedule words for rounds 16..63 are computed in a
// 16-word shift window of registers that tracks the RAM contents, and the
// new word is written back into the RAM as in a read-modify-write. At
// message end the padding bytes go through the same byte path, one per
// cycle while no full block is being compressed, followed by a pad step that
// pushes nothing, the two length words written in ST_LEN, and one or two
// final compressions; the eight digest words are then offered from the
// chaining registers through the output handshake, one per cycle while the
// receiver is ready, after which the chaining value returns to the initial
// hash. Input requests are accepted only in the idle state, so a request that
// fills no block and closes no message leaves the block idle and ready, and
// any other request holds off the next one until the compression work (and
// at message end, the digest output) is done.
`include "sha256_stream_hasher_macros.svh"
module sha256_stream_hasher import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        message_end_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] digest_word_o,
  output logic        word_last_o
);
  state_e      state_q, state_d;
  logic [63:0] bit_count_q, bit_count_d;
  logic [5:0]  byte_q, byte_d;
  logic        fin_q, fin_d;        // message end seen, final blocks still to do
  logic        pad_q, pad_d;        // the 0x80 pad byte has been pushed
  logic        len_q, len_d;        // length words already placed in block
  logic [6:0]  rnd_q, rnd_d;
  logic [2:0]  outw_q, outw_d;
  logic [31:0] chain_q [8];
  logic [31:0] vars_q [8];
  logic [31:0] vars_nx [8];
  logic [31:0] win_q [16];          // rolling schedule window
  logic [31:0] cur_word_q, cur_word_d;

  logic             we;
  logic [WinAw-1:0] waddr, raddr;
  logic [31:0]      wdata, rdata;
  logic [31:0]      w_round, w_new;
  logic             push;
  logic [7:0]       push_byte;
  logic             accept;

  sha_ram #(.Width(WordW), .Depth(WinDepth)) u_sched (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // For rounds below 16 the word comes from the RAM, read in the cycle before.
  assign w_new   = win_q[0] + sig0(win_q[1]) + win_q[9] + sig1(win_q[14]);
  assign w_round = (rnd_q < 7'd16) ? rdata : w_new;

  sha_round u_round (
    .v_i(vars_q), .k_i(ROUND_K[rnd_q[5:0]]), .w_i(w_round), .v_o(vars_nx)
  );

  assign accept        = valid_i && ready_o;
  assign ready_o       = (state_q == ST_IDLE);
  assign valid_o       = (state_q == ST_OUT);
  assign digest_word_o = chain_q[outw_q];
  assign word_last_o   = (outw_q == 3'd7);

  always_comb begin
    state_d     = state_q;
    bit_count_d = bit_count_q;
    byte_d      = byte_q;
    fin_d       = fin_q;
    pad_d       = pad_q;
    len_d       = len_q;
    rnd_d       = rnd_q;
    outw_d      = outw_q;
    cur_word_d  = cur_word_q;
    push        = 1'b0;
    push_byte   = PAD_BYTE;
    we          = 1'b0;
    waddr       = byte_q[5:2];
    wdata       = 32'h0;
    raddr       = 4'd0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (byte_valid_i) begin
            push        = 1'b1;
            push_byte   = data_byte_i;
            bit_count_d = bit_count_q + 64'd8;
          end
          fin_d = message_end_i;
          if (message_end_i && !(byte_valid_i && byte_q == 6'd63)) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // First pad pushes 0x80, later pushes zeros until the length slot.
        push      = 1'b1;
        push_byte = pad_q ? 8'h00 : PAD_BYTE;
        pad_d     = 1'b1;
        if (pad_q && byte_q == 6'd56) begin
          push    = 1'b0;
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        we    = 1'b1;
        len_d = 1'b1;
        if (!len_q) begin
          waddr = 4'd14;
          wdata = bit_count_q[63:32];
        end else begin
          waddr   = 4'd15;
          wdata   = bit_count_q[31:0];
          byte_d  = 6'd0;
          state_d = ST_INIT;
          rnd_d   = 7'd0;
        end
      end
      ST_INIT: begin
        raddr   = 4'd0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        raddr = 4'(rnd_q[3:0] + 4'd1);
        rnd_d = rnd_q + 7'd1;
        if (rnd_q >= 7'd16) begin
          we    = 1'b1;
          waddr = rnd_q[3:0];
          wdata = w_new;
        end
        if (rnd_q == 7'd63) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        // After the length block the digest is ready; a block that filled
        // during a finishing message goes on with the padding; else back to idle.
        if (len_q) begin
          state_d = ST_OUT;
          outw_d  = 3'd0;
        end else if (fin_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (ready_i) begin
          outw_d = outw_q + 3'd1;
          if (outw_q == 3'd7) begin
            state_d     = ST_IDLE;
            bit_count_d = 64'd0;
            len_d       = 1'b0;
            fin_d       = 1'b0;
            pad_d       = 1'b0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (push) begin
      cur_word_d = {cur_word_q[23:0], push_byte};
      we         = 1'b1;
      waddr      = byte_q[5:2];
      wdata      = cur_word_d;
      byte_d     = byte_q + 6'd1;
      if (byte_q == 6'd63) begin
        state_d = ST_INIT;
        rnd_d   = 7'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_count_q <= 64'd0;
      byte_q      <= 6'd0;
      fin_q       <= 1'b0;
      pad_q       <= 1'b0;
      len_q       <= 1'b0;
      rnd_q       <= 7'd0;
      outw_q      <= 3'd0;
      chain_q     <= INIT_H;
    end else begin
      state_q     <= state_d;
      bit_count_q <= bit_count_d;
      byte_q      <= byte_d;
      fin_q       <= fin_d;
      pad_q       <= pad_d;
      len_q       <= len_d;
      rnd_q       <= rnd_d;
      outw_q      <= outw_d;
      if (state_q == ST_ADD) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= chain_q[i] + vars_q[i];
        end
      end else if (state_q == ST_OUT && ready_i && outw_q == 3'd7) begin
        chain_q <= INIT_H;
      end
    end
  end

  // Payload registers: working variables, window and byte packer.
  always_ff @(posedge clk_i) begin
    cur_word_q <= cur_word_d;
    if (state_q == ST_INIT) begin
      vars_q <= chain_q;
    end else if (state_q == ST_ROUND) begin
      vars_q <= vars_nx;
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= w_round;
    end
  end

  `SHA_ASSERT_IMP(a_out_only_in_out, clk_i, rst_ni, valid_o, !ready_o, "output while accepting")
  `SHA_ASSERT_NXT(a_last_to_idle, clk_i, rst_ni, valid_o && ready_i && word_last_o, ready_o,
    "no return to idle after last word")
  `SHA_ASSERT_IMP(a_round_range, clk_i, rst_ni, state_q == ST_ADD, $past(rnd_q) == 7'd63,
    "compression ended early")
endmodule

// ----- tb/sv/sha256_digest_checker.sv -----
// Digest checker for the SHA-256 stream hasher: watches both request channels,
// computes the expected digest words and compares them. Depends on sha_pkg.
`timescale 1ns / 100ps
module sha256_digest_checker import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        message_end_i,
  input  logic        valid_o,
  input  logic        ready_i,
  input  logic [31:0] digest_word_o,
  input  logic        word_last_o,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_req_t;

  logic [31:0] hash_h [8];
  logic [31:0] blk_w [16];
  logic [63:0] msg_bits;
  logic [5:0]  blk_fill;
  digest_req_t digest_q [$];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] v [8];
    logic [31:0] w, t1, t2, a15, a2;
    for (int i = 0; i < 8; i++) v[i] = hash_h[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = blk_w[t];
      end else begin
        a15 = blk_w[(t - 15) & 15];
        a2 = blk_w[(t - 2) & 15];
        w = blk_w[t & 15] + (rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3))
          + blk_w[(t - 7) & 15] + (rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10));
        blk_w[t & 15] = w;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] = hash_h[i] + v[i];
  endtask

  task automatic shift_in(input logic [7:0] b);
    blk_w[blk_fill[5:2]] = {blk_w[blk_fill[5:2]][23:0], b};
    blk_fill = blk_fill + 6'd1;
    if (blk_fill == 6'd0) compress();
  endtask

  task automatic take_request(input logic [7:0] b, input logic bv, input logic fin);
    digest_req_t exp_item;
    if (bv) begin
      msg_bits = msg_bits + 64'd8;
      shift_in(b);
    end
    if (fin) begin
      shift_in(PAD_BYTE);
      while (blk_fill != 6'd56) shift_in(8'h00);
      blk_w[14] = msg_bits[63:32];
      blk_w[15] = msg_bits[31:0];
      compress();
      for (int k = 0; k < 8; k++) begin
        exp_item.word = hash_h[k];
        exp_item.last = (k == 7);
        digest_q = {digest_q, exp_item};
      end
      for (int k = 0; k < 8; k++) hash_h[k] = INIT_H[k];
      msg_bits = '0;
      blk_fill = '0;
    end
  endtask

  initial begin
    for (int k = 0; k < 8; k++) hash_h[k] = INIT_H[k];
    for (int k = 0; k < 16; k++) blk_w[k] = '0;
    msg_bits = '0;
    blk_fill = '0;
    fail_count_o = 0;
  end

  assign pending_o = digest_q.size();

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Output side first: a digest can't be caused by a request in the same edge.
      if (valid_o && ready_i) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest request word=%h last=%b",
                   $time, digest_word_o, word_last_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          digest_req_t exp_r;
          exp_r = digest_q.pop_front();
          if (exp_r.word !== digest_word_o || exp_r.last !== word_last_o) begin
            $display("%0t: digest mismatch expected word=%h last=%b actual word=%h last=%b",
                     $time, exp_r.word, exp_r.last, digest_word_o, word_last_o);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (valid_i && ready_o) take_request(data_byte_i, byte_valid_i, message_end_i);
    end
  end

endmodule

// ----- tb/sv/tb_sha256_stream_hasher.sv -----
// Testbench top for the SHA-256 stream hasher: drives byte requests, stalls
// the digest side and gives the verdict. Depends on the hasher and the checker.
`timescale 1ns / 100ps
module tb_sha256_stream_hasher;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        byte_valid_i = 1'b0;
  logic        message_end_i = 1'b0;
  logic        valid_o;
  logic        ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic        word_last_o;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          send_idle_pct = 21;
  int          recv_idle_pct = 64;

  // Worst case: up to about 640 requests, each possibly a message end with 8
  // stalled digest words plus two compressions and padding; well above that.
  localparam int CycleLimit = 400000;

  always #10 clk_i = ~clk_i;

  sha256_stream_hasher DUT (.*);

  sha256_digest_checker u_checker (
    .clk_i, .rst_ni, .valid_i, .ready_o, .data_byte_i, .byte_valid_i,
    .message_end_i, .valid_o, .ready_i, .digest_word_o, .word_last_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // The receiver stalls at random; the pattern changes per phase.
  always @(posedge clk_i) begin
    ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Sends one request: optional idle cycles first, then valid held until accepted.
  task automatic send_request(input logic [7:0] b, input logic bv, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    data_byte_i <= b;
    byte_valid_i <= bv;
    message_end_i <= fin;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      // Sprinkle empty requests and ignored bytes through the message.
      if ($urandom_range(9) == 0) send_request(8'($urandom_range(255)), 1'b0, 1'b0);
      if (i == len - 1 && $urandom_range(1)) begin
        send_request(8'($urandom_range(255)), 1'b1, 1'b1);
        return;
      end
      send_request(8'($urandom_range(255)), 1'b1, 1'b0);
    end
    send_request(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int sent;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, "abc", ignored byte, empty request, extremes,
    // and the 56/64-byte padding boundaries.
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    drain();
    // Sender pauses here until every expected digest word has come.
    for (int i = 0; i < 56; i++) send_request(8'h00, 1'b1, i == 55);
    for (int i = 0; i < 64; i++) send_request(8'(i), 1'b1, i == 63);

    // Random phases: mostly short messages, a few across block boundaries.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 64 : 0;
      recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 21 : 0;
      sent = 0;
      while (sent < 20) begin
        int len;
        len = ($urandom_range(5) == 0) ? $urandom_range(50, 66) : $urandom_range(0, 12);
        send_message(len);
        sent += len + 1;
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/sha_pkg.sv
src/sha_ram.sv
src/sha_round.sv
src/sha256_stream_hasher.sv
tb/sv/sha256_digest_checker.sv
tb/sv/tb_sha256_stream_hasher.sv
